@@ sv/roberts_cross_edge_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef ROBERTS_CROSS_EDGE_ASSERT_SVH
`define ROBERTS_CROSS_EDGE_ASSERT_SVH

// Holds at every edge, reset included.
`define RCE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Same-cycle implication, off while in reset.
`define RCE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define RCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/rce_pkg.sv @@
package rce_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int WIDTH_REG_BITS = 11;
    localparam int ROW_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [ROW_BITS-1:0]       HEIGHT_RESET = 16'd1024;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    // result kinds a pixel can trigger, in emission order
    localparam int NUM_KINDS  = 4;
    localparam int RES_DIAG   = 0;  // full window above-left
    localparam int RES_RIGHT  = 1;  // right edge of the row above
    localparam int RES_BOTTOM = 2;  // bottom row, left neighbor
    localparam int RES_CORNER = 3;  // bottom right pixel

endpackage

@@ sv/rce_if.sv @@
interface rce_pixel_if #(
    parameter int PIXEL_BITS = rce_pkg::PIXEL_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface rce_result_if #(
    parameter int PIXEL_BITS = rce_pkg::PIXEL_BITS_DEF,
    parameter int COL_BITS   = $clog2(rce_pkg::MAX_WIDTH_DEF)
) ();
    logic                         valid;
    logic                         ready;
    logic [PIXEL_BITS-1:0]        edge_value;
    logic [rce_pkg::ROW_BITS-1:0] out_row;
    logic [COL_BITS-1:0]          out_col;
    logic                         last_of_run;
    logic                         frame_done;

    modport source (output valid, output edge_value, output out_row, output out_col,
                    output last_of_run, output frame_done, input ready);
    modport sink   (input valid, input edge_value, input out_row, input out_col,
                    input last_of_run, input frame_done, output ready);
endinterface

interface rce_cfg_if ();
    logic                               valid;
    logic                               ready;
    logic [rce_pkg::CFG_INDEX_BITS-1:0] index;
    logic [rce_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/rce_front.sv @@
module rce_front #(
    parameter int MAX_WIDTH  = rce_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = rce_pkg::PIXEL_BITS_DEF,
    parameter int COL_BITS   = $clog2(rce_pkg::MAX_WIDTH_DEF),
    parameter type job_t     = logic
) (
    input  logic         clk,
    input  logic         rst_n,
    rce_pixel_if.sink    pixels,
    rce_cfg_if.sink      cfg,
    output job_t         job,
    output logic         job_valid,
    input  logic         job_ready
);
    import rce_pkg::*;

    logic [WIDTH_REG_BITS-1:0] width_reg;
    logic [ROW_BITS-1:0]       height_reg;
    logic [COL_BITS-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0]       row_reg, row_next;
    logic [COL_BITS-1:0]       last_col;
    logic [ROW_BITS-1:0]       last_row;
    logic                      row_end, on_last_row;
    logic                      accept, cfg_write, restart, s1_leave;
    logic [NUM_KINDS-1:0]      kinds;

    logic [PIXEL_BITS-1:0]     line_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]     up_reg, pix_reg, left_reg, ul_reg;
    logic                      s1_valid_reg;
    logic [COL_BITS-1:0]       s1_col_reg, s1_last_col_reg;
    logic [ROW_BITS-1:0]       s1_row_reg;
    logic                      s1_row_end_reg, s1_last_row_reg;

    // effective frame size: zero means one, width saturates at the line store size
    always_comb
    begin
        if (width_reg == '0)
            last_col = '0;
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            last_col = COL_BITS'(MAX_WIDTH - 1);
        else
            last_col = COL_BITS'(width_reg - 1'b1);
        last_row = (height_reg == '0) ? '0 : height_reg - 1'b1;
    end

    assign row_end     = (col_reg == last_col);
    assign on_last_row = (row_reg == last_row);
    assign col_next    = row_end ? '0 : col_reg + 1'b1;
    assign row_next    = row_end ? (on_last_row ? '0 : row_reg + 1'b1) : row_reg;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        unique case (cfg_reg_t'(cfg.index))
            REG_IMAGE_WIDTH:  restart = cfg_write;
            REG_IMAGE_HEIGHT: restart = cfg_write;
            default:          restart = 1'b0;
        endcase
    end

    // which results the staged pixel completes
    always_comb
    begin
        kinds             = '0;
        kinds[RES_DIAG]   = (s1_row_reg != '0) && (s1_col_reg != '0);
        kinds[RES_RIGHT]  = (s1_row_reg != '0) && s1_row_end_reg;
        kinds[RES_BOTTOM] = s1_last_row_reg && (s1_col_reg != '0);
        kinds[RES_CORNER] = s1_last_row_reg && s1_row_end_reg;
    end

    // words with no result drop out here and never enter the queue
    assign job_valid    = s1_valid_reg && (kinds != '0);
    assign s1_leave     = s1_valid_reg && (job_ready || (kinds == '0));
    assign pixels.ready = !s1_valid_reg || job_ready || (kinds == '0);
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        job            = '0;
        job.pixel      = pix_reg;
        job.up         = up_reg;
        job.left       = left_reg;
        job.upper_left = ul_reg;
        job.row        = s1_row_reg;
        job.col        = s1_col_reg;
        job.last_col   = s1_last_col_reg;
        job.kinds      = kinds;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
            ul_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    REG_IMAGE_WIDTH:  width_reg  <= cfg.data[WIDTH_REG_BITS-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg.data[ROW_BITS-1:0];
                    default:          ;
                endcase
            end
            if (restart)
            begin
                col_reg  <= '0;
                row_reg  <= '0;
                left_reg <= '0;
                ul_reg   <= '0;
            end
            else
            begin
                if (accept)
                begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                end
                if (s1_leave)
                begin
                    left_reg <= pix_reg;
                    ul_reg   <= up_reg;
                end
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_leave)
                s1_valid_reg <= 1'b0;
        end
    end

    // line store: read-first, the old entry is the pixel above
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_reg            <= line_mem[col_reg];
            line_mem[col_reg] <= pixels.pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg         <= pixels.pixel;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= last_col;
            s1_row_end_reg  <= row_end;
            s1_last_row_reg <= on_last_row;
        end
    end

endmodule

@@ sv/rce_queue.sv @@
module rce_queue #(
    parameter type job_t = logic,
    parameter int DEPTH  = rce_pkg::QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);
    import rce_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    job_t                slots [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                push, pop;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] ptr);
        return (ptr == PTR_BITS'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_job;
    end

endmodule

@@ sv/rce_back.sv @@
module rce_back #(
    parameter int PIXEL_BITS = rce_pkg::PIXEL_BITS_DEF,
    parameter int COL_BITS   = $clog2(rce_pkg::MAX_WIDTH_DEF),
    parameter type job_t     = logic
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  job_t          job,
    rce_result_if.source  results
);
    import rce_pkg::*;

    job_t                  job_reg;
    logic [NUM_KINDS-1:0]  kinds_left, kinds_after;
    logic                  out_free, fire;
    logic [PIXEL_BITS-1:0] diff_a, diff_b;
    logic [PIXEL_BITS:0]   sum_diag, sum_right, sum_bottom;
    logic [PIXEL_BITS-1:0] res_value;
    logic [ROW_BITS-1:0]   res_row;
    logic [COL_BITS-1:0]   res_col;
    logic                  res_done;

    logic                  out_valid_reg;
    logic [PIXEL_BITS-1:0] edge_value_reg;
    logic [ROW_BITS-1:0]   out_row_reg;
    logic [COL_BITS-1:0]   out_col_reg;
    logic                  last_of_run_reg, frame_done_reg;

    function automatic logic [PIXEL_BITS-1:0] abs_diff(input logic [PIXEL_BITS-1:0] a,
                                                       input logic [PIXEL_BITS-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    assign out_free    = !out_valid_reg || results.ready;
    assign fire        = out_free && (job_reg.kinds != '0);
    assign kinds_left  = job_reg.kinds & (job_reg.kinds - 1'b1);  // drop lowest pending kind
    assign kinds_after = fire ? kinds_left : job_reg.kinds;
    assign job_ready   = (kinds_after == '0);

    assign diff_a     = abs_diff(job_reg.upper_left, job_reg.pixel);
    assign diff_b     = abs_diff(job_reg.left, job_reg.up);
    assign sum_diag   = {1'b0, diff_a} + {1'b0, diff_b};
    assign sum_right  = {1'b0, job_reg.up} + {1'b0, job_reg.pixel};
    assign sum_bottom = {1'b0, job_reg.left} + {1'b0, job_reg.pixel};

    // beyond the right or bottom edge the missing pixels are zero
    always_comb
    begin
        priority if (job_reg.kinds[RES_DIAG])
        begin
            res_value = sum_diag[PIXEL_BITS:1];
            res_row   = job_reg.row - 1'b1;
            res_col   = job_reg.col - 1'b1;
            res_done  = 1'b0;
        end
        else if (job_reg.kinds[RES_RIGHT])
        begin
            res_value = sum_right[PIXEL_BITS:1];
            res_row   = job_reg.row - 1'b1;
            res_col   = job_reg.last_col;
            res_done  = 1'b0;
        end
        else if (job_reg.kinds[RES_BOTTOM])
        begin
            res_value = sum_bottom[PIXEL_BITS:1];
            res_row   = job_reg.row;
            res_col   = job_reg.col - 1'b1;
            res_done  = 1'b0;
        end
        else
        begin
            res_value = job_reg.pixel >> 1;
            res_row   = job_reg.row;
            res_col   = job_reg.last_col;
            res_done  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid && job_ready)
                job_reg <= job;
            else
                job_reg.kinds <= kinds_after;
            if (out_free)
                out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            edge_value_reg  <= res_value;
            out_row_reg     <= res_row;
            out_col_reg     <= res_col;
            last_of_run_reg <= (kinds_left == '0);
            frame_done_reg  <= res_done;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.edge_value  = edge_value_reg;
    assign results.out_row     = out_row_reg;
    assign results.out_col     = out_col_reg;
    assign results.last_of_run = last_of_run_reg;
    assign results.frame_done  = frame_done_reg;

endmodule

@@ sv/roberts_cross_edge.sv @@
// Roberts cross edge detector on a raster pixel stream.
// pixels:  one pixel per word, raster order from frame start.
// results: edge value tagged with row and column; last_of_run marks the final
//          result of an input pixel, frame_done the bottom right pixel.
// cfg:     index 0 image_width, index 1 image_height; always ready. A write
//          restarts the frame at row 0, column 0; write only while idle.
// A pixel is taken every cycle while the 4-entry job queue has room. The
// result engine sends one result per cycle while the output is not stalled:
// one per pixel in the body, two at each row end and along the bottom row,
// four at the bottom right pixel, so the sustained rate is set by that engine.
// The first result of a pixel passes the input stage with line store read,
// a queue slot, the job register and the output register on its way to the
// port.
// A stalled result holds the output register; the queue fills and then the
// pixel channel drops ready. Nothing is lost.
// Reset empties the pipeline and sets both sizes to 1024; the line store is
// not cleared, row 0 fills it before any value read from it is used.
module roberts_cross_edge #(
    parameter int MAX_WIDTH  = rce_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = rce_pkg::PIXEL_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rce_pixel_if.sink     pixels,
    rce_result_if.source  results,
    rce_cfg_if.sink       cfg
);
    import rce_pkg::*;

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic [PIXEL_BITS-1:0] up;
        logic [PIXEL_BITS-1:0] left;
        logic [PIXEL_BITS-1:0] upper_left;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic [COL_BITS-1:0]   last_col;
        logic [NUM_KINDS-1:0]  kinds;
    } job_t;

    job_t front_job, back_job;
    logic front_valid, front_ready;
    logic back_valid, back_ready;

    rce_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_BITS   (COL_BITS),
        .job_t      (job_t)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .cfg       (cfg),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    rce_queue #(
        .job_t (job_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    rce_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .COL_BITS   (COL_BITS),
        .job_t      (job_t)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .results   (results)
    );

endmodule

@@ sv/rce_checker.sv @@
`include "roberts_cross_edge_assert.svh"

module rce_checker #(
    parameter int PIXEL_BITS = rce_pkg::PIXEL_BITS_DEF,
    parameter int COL_BITS   = $clog2(rce_pkg::MAX_WIDTH_DEF)
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [PIXEL_BITS-1:0]        edge_value,
    input logic [rce_pkg::ROW_BITS-1:0] out_row,
    input logic [COL_BITS-1:0]          out_col,
    input logic                         last_of_run,
    input logic                         frame_done
);
    import rce_pkg::*;

    logic res_fire;
    logic frame_start_reg;

    assign res_fire = res_valid && res_ready;

    // the first result of every frame belongs to row 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_start_reg <= 1'b1;
        else if (res_fire)
            frame_start_reg <= frame_done;
    end

    `RCE_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !res_valid, "result during reset")
    `RCE_ASSERT_IMPLY(a_done_ends_run, clk, rst_n, res_valid && frame_done, last_of_run, "frame_done without last_of_run")
    `RCE_ASSERT_IMPLY(a_frame_starts_row0, clk, rst_n, res_valid && frame_start_reg, out_row == '0, "frame does not start at row 0")
    `RCE_ASSERT_NEXT(a_stall_holds, clk, rst_n, res_valid && !res_ready, res_valid && $stable(edge_value) && $stable(out_row) && $stable(out_col) && $stable(last_of_run) && $stable(frame_done), "stalled result changed")

endmodule

bind roberts_cross_edge rce_checker #(
    .PIXEL_BITS (PIXEL_BITS),
    .COL_BITS   (COL_BITS)
) u_rce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (results.valid),
    .res_ready   (results.ready),
    .edge_value  (results.edge_value),
    .out_row     (results.out_row),
    .out_col     (results.out_col),
    .last_of_run (results.last_of_run),
    .frame_done  (results.frame_done)
);
